@@ sv/lsmd_pkg.sv @@
// Package of shared types and constants for the lidar sector minimum distance unit.
`default_nettype none
package lsmd_pkg;

  // Field widths
  localparam int unsigned DistW = 16;
  localparam int unsigned CoordW = 16;
  localparam int unsigned LatW = 15;
  localparam int unsigned CntW = 11;
  localparam int unsigned CfgIdxW = 4;
  localparam int unsigned CfgDataW = 16;

  // Scan capacity, clamped to the largest count that the count width can hold
  localparam int unsigned MaxScanPoints = 1024;
  localparam int unsigned TallyLimit = (1 << CntW) - 1;
  localparam logic [CntW-1:0] ScanCap =
    CntW'((MaxScanPoints > TallyLimit) ? TallyLimit : MaxScanPoints);

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegIgnoreNear = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegFrontHalfWidth = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] RegSideMinForward = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] RegSideMinLateral = CfgIdxW'(3);

  // Configuration reset values
  localparam logic [DistW-1:0] IgnoreNearRst = DistW'(40);
  localparam logic [LatW-1:0] FrontHalfWidthRst = LatW'(180);
  localparam logic signed [CoordW-1:0] SideMinForwardRst = -CoordW'(40);
  localparam logic [LatW-1:0] SideMinLateralRst = LatW'(80);

  // Queue depth
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW = $clog2(QDepth);
  localparam int unsigned QCntW = $clog2(QDepth + 1);

  // Classified point passed from front to back
  typedef struct packed {
    logic [DistW-1:0] dist_mm;
    logic pt_valid;
    logic hit_front;
    logic hit_left;
    logic hit_right;
    logic last;
  } point_item_t;

endpackage
`default_nettype wire

@@ sv/lsmd_front.sv @@
// Front end: configuration registers and zone classification of each point.
`default_nettype none
module lsmd_front (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [lsmd_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  wire logic [lsmd_pkg::CfgDataW-1:0]      cfg_wdata_i,
  input  wire logic                               point_valid_i,
  input  wire logic [lsmd_pkg::DistW-1:0]         distance_mm_i,
  input  wire logic signed [lsmd_pkg::CoordW-1:0] x_mm_i,
  input  wire logic signed [lsmd_pkg::CoordW-1:0] y_mm_i,
  input  wire logic                               last_point_i,
  output lsmd_pkg::point_item_t                   item_o
);
  import lsmd_pkg::*;

  logic [DistW-1:0]         ignore_near_q;
  logic [LatW-1:0]          front_half_width_q;
  logic signed [CoordW-1:0] side_min_forward_q;
  logic [LatW-1:0]          side_min_lateral_q;

  logic signed [CoordW:0] y_ext;
  logic [CoordW:0]        abs_y;
  logic signed [CoordW:0] lat_pos;
  logic signed [CoordW:0] lat_neg;
  logic                   use_pt;
  logic                   x_pos;
  logic                   x_side;
  logic                   left_zone;

  // Write configuration registers; ignore unknown indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ignore_near_q      <= IgnoreNearRst;
      front_half_width_q <= FrontHalfWidthRst;
      side_min_forward_q <= SideMinForwardRst;
      side_min_lateral_q <= SideMinLateralRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegIgnoreNear:     ignore_near_q      <= cfg_wdata_i[DistW-1:0];
        RegFrontHalfWidth: front_half_width_q <= cfg_wdata_i[LatW-1:0];
        RegSideMinForward: side_min_forward_q <= cfg_wdata_i[CoordW-1:0];
        RegSideMinLateral: side_min_lateral_q <= cfg_wdata_i[LatW-1:0];
        default: ;
      endcase
    end
  end

  // Classify the point against the zones
  always_comb begin
    y_ext     = {y_mm_i[CoordW-1], y_mm_i};
    abs_y     = y_ext[CoordW] ? (CoordW+1)'(-y_ext) : y_ext;
    lat_pos   = {2'b00, side_min_lateral_q};
    lat_neg   = -lat_pos;
    use_pt    = point_valid_i && (distance_mm_i >= ignore_near_q);
    x_pos     = !x_mm_i[CoordW-1] && (x_mm_i != '0);
    x_side    = x_mm_i >= side_min_forward_q;
    left_zone = x_side && (y_ext >= lat_pos);

    item_o.dist_mm   = distance_mm_i;
    item_o.pt_valid  = point_valid_i;
    item_o.hit_front = use_pt && x_pos && (abs_y <= {2'b00, front_half_width_q});
    item_o.hit_left  = use_pt && left_zone;
    item_o.hit_right = use_pt && !left_zone && x_side && (y_ext <= lat_neg);
    item_o.last      = last_point_i;
  end

endmodule
`default_nettype wire

@@ sv/lsmd_queue.sv @@
// Short queue of classified points between front and back.
`default_nettype none
module lsmd_queue (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push_i,
  input  wire lsmd_pkg::point_item_t push_item_i,
  output logic                       full_o,
  input  wire logic                  pop_i,
  output logic                       valid_o,
  output lsmd_pkg::point_item_t      item_o
);
  import lsmd_pkg::*;

  point_item_t           entry_q [QDepth];
  logic [QPtrW-1:0]      wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0]      rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0]      count_q, count_d;

  assign full_o  = (count_q == QCntW'(QDepth));
  assign valid_o = (count_q != '0);
  assign item_o  = entry_q[rd_ptr_q];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the pushed word
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule
`default_nettype wire

@@ sv/lsmd_back.sv @@
// Back end: running minima, saturating counts and the result register.
`default_nettype none
module lsmd_back (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        q_valid_i,
  input  wire lsmd_pkg::point_item_t       q_item_i,
  output logic                             pop_o,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [lsmd_pkg::DistW-1:0]       front_closest_o,
  output logic [lsmd_pkg::DistW-1:0]       left_closest_o,
  output logic [lsmd_pkg::DistW-1:0]       right_closest_o,
  output logic [lsmd_pkg::CntW-1:0]        valid_count_o,
  output logic [lsmd_pkg::CntW-1:0]        total_count_o,
  output logic                             scan_seen_o
);
  import lsmd_pkg::*;

  logic [DistW-1:0] front_best_q, front_best_d;
  logic [DistW-1:0] left_best_q, left_best_d;
  logic [DistW-1:0] right_best_q, right_best_d;
  logic [CntW-1:0]  valid_tally_q, valid_tally_d;
  logic [CntW-1:0]  point_tally_q, point_tally_d;
  logic [DistW-1:0] res_front_q;
  logic [DistW-1:0] res_left_q;
  logic [DistW-1:0] res_right_q;
  logic [CntW-1:0]  res_valid_cnt_q;
  logic [CntW-1:0]  res_total_cnt_q;
  logic             res_seen_q;
  logic             out_valid_q;
  logic             out_free;
  logic             room;
  logic             emit;

  function automatic logic [DistW-1:0] keep_nearer(logic [DistW-1:0] held,
                                                   logic [DistW-1:0] cand);
    logic [DistW-1:0] res;
    res = held;
    if (cand != '0 && (held == '0 || cand < held)) begin
      res = cand;
    end
    return res;
  endfunction

  // Take a word unless it closes a scan while the result register holds a stalled result
  assign out_free    = !out_valid_q || !out_stall_i;
  assign pop_o       = q_valid_i && (!q_item_i.last || out_free);
  assign emit        = pop_o && q_item_i.last;
  assign room        = point_tally_q < ScanCap;
  assign out_valid_o = out_valid_q;

  assign front_closest_o = res_front_q;
  assign left_closest_o  = res_left_q;
  assign right_closest_o = res_right_q;
  assign valid_count_o   = res_valid_cnt_q;
  assign total_count_o   = res_total_cnt_q;
  assign scan_seen_o     = res_seen_q;

  // Fold the point into the scan state; drop it once the scan is full
  always_comb begin
    front_best_d  = front_best_q;
    left_best_d   = left_best_q;
    right_best_d  = right_best_q;
    valid_tally_d = valid_tally_q;
    point_tally_d = point_tally_q;
    if (room) begin
      point_tally_d = point_tally_q + 1'b1;
      if (q_item_i.pt_valid) begin
        valid_tally_d = valid_tally_q + 1'b1;
      end
      if (q_item_i.hit_front) begin
        front_best_d = keep_nearer(front_best_q, q_item_i.dist_mm);
      end
      if (q_item_i.hit_left) begin
        left_best_d = keep_nearer(left_best_q, q_item_i.dist_mm);
      end
      if (q_item_i.hit_right) begin
        right_best_d = keep_nearer(right_best_q, q_item_i.dist_mm);
      end
    end
  end

  // Update scan state; clear it when the result is loaded
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_best_q  <= '0;
      left_best_q   <= '0;
      right_best_q  <= '0;
      valid_tally_q <= '0;
      point_tally_q <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (emit) begin
        front_best_q  <= '0;
        left_best_q   <= '0;
        right_best_q  <= '0;
        valid_tally_q <= '0;
        point_tally_q <= '0;
      end else if (pop_o) begin
        front_best_q  <= front_best_d;
        left_best_q   <= left_best_d;
        right_best_q  <= right_best_d;
        valid_tally_q <= valid_tally_d;
        point_tally_q <= point_tally_d;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Load the result register
  always_ff @(posedge clk_i) begin
    if (emit) begin
      res_front_q     <= front_best_d;
      res_left_q      <= left_best_d;
      res_right_q     <= right_best_d;
      res_valid_cnt_q <= valid_tally_d;
      res_total_cnt_q <= point_tally_d;
      res_seen_q      <= (valid_tally_d != '0);
    end
  end

endmodule
`default_nettype wire

@@ sv/lidar_sector_min_distance_unit.sv @@
// Top level of the lidar sector minimum distance unit.
// Timing: a result word passes the queue and then the result register after its last point is
// taken, and is offered later while older words still wait in the queue or a result is stalled.
// Throughput: one point per cycle while the queue is not full; the two-entry queue and the result
// register let points of the next scan enter while a result waits.
// Reset: asynchronous, active low; registers to defaults, scan state and queue empty.
`default_nettype none
module lidar_sector_min_distance_unit (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [lsmd_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  wire logic [lsmd_pkg::CfgDataW-1:0]      cfg_wdata_i,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic                               point_valid_i,
  input  wire logic [lsmd_pkg::DistW-1:0]         distance_mm_i,
  input  wire logic signed [lsmd_pkg::CoordW-1:0] x_mm_i,
  input  wire logic signed [lsmd_pkg::CoordW-1:0] y_mm_i,
  input  wire logic                               last_point_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic [lsmd_pkg::DistW-1:0]              front_closest_o,
  output logic [lsmd_pkg::DistW-1:0]              left_closest_o,
  output logic [lsmd_pkg::DistW-1:0]              right_closest_o,
  output logic [lsmd_pkg::CntW-1:0]               valid_count_o,
  output logic [lsmd_pkg::CntW-1:0]               total_count_o,
  output logic                                    scan_seen_o
);
  import lsmd_pkg::*;

  point_item_t front_item;
  point_item_t q_item;
  logic        q_full;
  logic        q_valid;
  logic        q_pop;
  logic        push;

  // Accept a word whenever the queue has room
  assign in_stall_o = q_full;
  assign push       = in_valid_i && !q_full;

  lsmd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .point_valid_i (point_valid_i),
    .distance_mm_i (distance_mm_i),
    .x_mm_i        (x_mm_i),
    .y_mm_i        (y_mm_i),
    .last_point_i  (last_point_i),
    .item_o        (front_item)
  );

  lsmd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (front_item),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .item_o      (q_item)
  );

  lsmd_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_item_i        (q_item),
    .pop_o           (q_pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .front_closest_o (front_closest_o),
    .left_closest_o  (left_closest_o),
    .right_closest_o (right_closest_o),
    .valid_count_o   (valid_count_o),
    .total_count_o   (total_count_o),
    .scan_seen_o     (scan_seen_o)
  );

endmodule
`default_nettype wire

@@ bench/lidar_sector_min_distance_unit_test.sv @@
// Self-checking bench for the lidar sector minimum distance unit.
`timescale 1ns / 100ps

module lidar_sector_min_distance_unit_test;
  import lsmd_pkg::*;

  // One scan point as sent on the input channel
  typedef struct {
    logic                     pt_valid;
    logic [DistW-1:0]         dist_mm;
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic                     last;
  } lidar_point_t;

  // One scan summary as expected on the output channel
  typedef struct {
    logic [DistW-1:0] front_mm;
    logic [DistW-1:0] left_mm;
    logic [DistW-1:0] right_mm;
    logic [CntW-1:0]  valid_cnt;
    logic [CntW-1:0]  total_cnt;
    logic             have;
  } scan_summary_t;

  // First index past the defined registers
  localparam logic [CfgIdxW-1:0] SpareReg = CfgIdxW'(RegSideMinLateral + 1);

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]       cfg_idx_i = '0;
  logic [CfgDataW-1:0]      cfg_wdata_i = '0;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  logic                     point_valid_i = 1'b0;
  logic [DistW-1:0]         distance_mm_i = '0;
  logic signed [CoordW-1:0] x_mm_i = '0;
  logic signed [CoordW-1:0] y_mm_i = '0;
  logic                     last_point_i = 1'b0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic [DistW-1:0]         front_closest_o;
  logic [DistW-1:0]         left_closest_o;
  logic [DistW-1:0]         right_closest_o;
  logic [CntW-1:0]          valid_count_o;
  logic [CntW-1:0]          total_count_o;
  logic                     scan_seen_o;

  // Bench-side copy of the zone registers
  logic [DistW-1:0]         near_limit = IgnoreNearRst;
  logic [LatW-1:0]          corridor_half = FrontHalfWidthRst;
  logic signed [CoordW-1:0] side_fwd = SideMinForwardRst;
  logic [LatW-1:0]          side_lat = SideMinLateralRst;

  // Bench-side copy of the running scan state
  logic [DistW-1:0] front_near = '0;
  logic [DistW-1:0] left_near = '0;
  logic [DistW-1:0] right_near = '0;
  logic [CntW-1:0]  valid_pts = '0;
  logic [CntW-1:0]  total_pts = '0;

  scan_summary_t pending_summaries[$];
  int            fail_count = 0;
  logic          idle_on = 1'b1;
  int            hold_cycles = 0;

  lidar_sector_min_distance_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .point_valid_i   (point_valid_i),
    .distance_mm_i   (distance_mm_i),
    .x_mm_i          (x_mm_i),
    .y_mm_i          (y_mm_i),
    .last_point_i    (last_point_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .front_closest_o (front_closest_o),
    .left_closest_o  (left_closest_o),
    .right_closest_o (right_closest_o),
    .valid_count_o   (valid_count_o),
    .total_count_o   (total_count_o),
    .scan_seen_o     (scan_seen_o)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // Zero means no hit, so a zero candidate never replaces the held value
  function automatic logic [DistW-1:0] nearer(logic [DistW-1:0] held, logic [DistW-1:0] cand);
    if (cand == '0) return held;
    if (held == '0 || cand < held) return cand;
    return held;
  endfunction

  // Fold one accepted point into the scan state; queue a summary on the last one
  function automatic void take_point(lidar_point_t p);
    int xi;
    int yi;
    int ay;
    int lat;
    int fwd;
    scan_summary_t s;
    xi = p.x;
    yi = p.y;
    ay = (yi < 0) ? -yi : yi;
    lat = int'(side_lat);
    fwd = side_fwd;
    // drop points once the scan is full
    if (total_pts < ScanCap) begin
      total_pts++;
      if (p.pt_valid) valid_pts++;
      if (p.pt_valid && p.dist_mm >= near_limit) begin
        if (xi > 0 && ay <= int'(corridor_half)) front_near = nearer(front_near, p.dist_mm);
        if (xi >= fwd && yi >= lat) begin
          left_near = nearer(left_near, p.dist_mm);
        end else if (xi >= fwd && yi <= -lat) begin
          right_near = nearer(right_near, p.dist_mm);
        end
      end
    end
    if (p.last) begin
      s.front_mm = front_near;
      s.left_mm = left_near;
      s.right_mm = right_near;
      s.valid_cnt = valid_pts;
      s.total_cnt = total_pts;
      s.have = (valid_pts != '0);
      pending_summaries.push_back(s);
      front_near = '0;
      left_near = '0;
      right_near = '0;
      valid_pts = '0;
      total_pts = '0;
    end
  endfunction

  function automatic void check_field(string what, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
      fail_count++;
    end
  endfunction

  // Compare every accepted result word with the oldest pending summary
  always @(posedge clk_i) begin : result_check
    scan_summary_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_summaries.size() == 0) begin
        $display("%0t: unexpected result word: expected none, actual front %0d points %0d",
                 $time, front_closest_o, total_count_o);
        fail_count++;
      end else begin
        want = pending_summaries.pop_front();
        check_field("front_closest", want.front_mm, front_closest_o);
        check_field("left_closest", want.left_mm, left_closest_o);
        check_field("right_closest", want.right_mm, right_closest_o);
        check_field("valid_count", want.valid_cnt, valid_count_o);
        check_field("total_count", want.total_cnt, total_count_o);
        check_field("scan_seen", want.have, scan_seen_o);
      end
    end
  end

  // Mostly short gaps, a few long ones; none while idling is off
  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Stall the result side in random runs; honor a long hold when one is requested
  initial begin : result_sink
    int run_left;
    logic stall_now;
    run_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        out_stall_i <= 1'b1;
        hold_cycles--;
        run_left = 0;
      end else if (run_left > 0) begin
        run_left--;
      end else begin
        stall_now = idle_on && ($urandom_range(0, 2) == 0);
        out_stall_i <= stall_now;
        run_left = stall_now ? pick_gap() : $urandom_range(0, 12);
      end
    end
  end

  // Offer one word after a gap and hold it until taken
  task automatic send_point(lidar_point_t p, int gap);
    @(negedge clk_i);
    repeat (gap) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    point_valid_i <= p.pt_valid;
    distance_mm_i <= p.dist_mm;
    x_mm_i <= p.x;
    y_mm_i <= p.y;
    last_point_i <= p.last;
    do @(posedge clk_i); while (in_stall_o);
    take_point(p);
  endtask

  // Pause the sender until every summary is back, then let the pipe settle
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_summaries.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      RegIgnoreNear: near_limit = val;
      RegFrontHalfWidth: corridor_half = val[LatW-1:0];
      RegSideMinForward: side_fwd = val;
      RegSideMinLateral: side_lat = val[LatW-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(logic [15:0] near_v, logic [15:0] half_v, logic [15:0] fwd_v,
                               logic [15:0] lat_v);
    write_reg(RegIgnoreNear, near_v);
    write_reg(RegFrontHalfWidth, half_v);
    write_reg(RegSideMinForward, fwd_v);
    write_reg(RegSideMinLateral, lat_v);
  endtask

  function automatic lidar_point_t pt(logic v, int d, int x, int y, logic last);
    lidar_point_t p;
    p.pt_valid = v;
    p.dist_mm = DistW'(d);
    p.x = CoordW'(x);
    p.y = CoordW'(y);
    p.last = last;
    return p;
  endfunction

  function automatic logic [15:0] near_to(int base, int spread);
    return 16'(base + int'($urandom_range(0, 2 * spread)) - spread);
  endfunction

  // Random point, biased toward the current zone edges
  function automatic lidar_point_t random_point(logic last);
    lidar_point_t p;
    int sgn;
    sgn = $urandom_range(0, 1) ? 1 : -1;
    p.pt_valid = ($urandom_range(0, 99) < 85);
    p.last = last;
    case ($urandom_range(0, 3))
      0: p.dist_mm = DistW'($urandom);
      1: p.dist_mm = near_to(int'(near_limit), 4);
      default: p.dist_mm = DistW'($urandom_range(0, 3000));
    endcase
    case ($urandom_range(0, 3))
      0: p.x = CoordW'($urandom);
      1: p.x = near_to(0, 4);
      2: p.x = near_to(int'(side_fwd), 4);
      default: p.x = CoordW'(int'($urandom_range(0, 6000)) - 3000);
    endcase
    case ($urandom_range(0, 3))
      0: p.y = CoordW'($urandom);
      1: p.y = near_to(sgn * int'(corridor_half), 4);
      2: p.y = near_to(sgn * int'(side_lat), 4);
      default: p.y = CoordW'(int'($urandom_range(0, 6000)) - 3000);
    endcase
    return p;
  endfunction

  function automatic int scan_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 12);
    if (r < 95) return $urandom_range(13, 60);
    return $urandom_range(61, 300);
  endfunction

  task automatic stream_scan(int len);
    for (int i = 0; i < len; i++) send_point(random_point(i == len - 1), pick_gap());
  endtask

  // Zone edges, thresholds and field extremes under the reset settings
  task automatic test_directed();
    // invalid point alone in its scan
    send_point(pt(0, 500, 100, 0, 1), pick_gap());
    send_point(pt(1, 39, 100, 0, 0), pick_gap());
    send_point(pt(1, 40, 100, 0, 0), pick_gap());
    send_point(pt(1, 300, 1, 180, 0), pick_gap());
    send_point(pt(1, 250, 1, 181, 0), pick_gap());
    send_point(pt(1, 200, 0, 0, 0), pick_gap());
    send_point(pt(1, 900, -40, -80, 0), pick_gap());
    send_point(pt(1, 950, -41, -200, 0), pick_gap());
    // most negative lateral offset
    send_point(pt(1, 65535, 32767, -32768, 0), pick_gap());
    send_point(pt(1, 700, 32767, 32767, 0), pick_gap());
    send_point(pt(0, 41, 10, 0, 0), pick_gap());
    send_point(pt(1, 60, -32768, 79, 0), pick_gap());
    send_point(pt(1, 600, 10, -79, 1), pick_gap());
    // front and left at once, on the last point
    send_point(pt(1, 45, 10, 100, 1), pick_gap());
    // zero distance is skipped under the default near limit
    send_point(pt(0, 65535, -1, -1, 0), pick_gap());
    send_point(pt(1, 0, 5, 5, 1), pick_gap());
    drain_results();
  endtask

  // Fill a scan past capacity so the counts saturate and the extra points drop
  task automatic test_scan_overflow();
    lidar_point_t p;
    idle_on = 1'b0;
    for (int i = 0; i < int'(ScanCap) + 6; i++) begin
      p = random_point(i == int'(ScanCap) + 5);
      p.pt_valid = 1'b1;
      send_point(p, pick_gap());
    end
    drain_results();
    idle_on = 1'b1;
  endtask

  // Hold the result side long enough that the input backs up
  task automatic test_backpressure();
    idle_on = 1'b0;
    hold_cycles = 200;
    repeat (40) stream_scan($urandom_range(1, 3));
    drain_results();
    idle_on = 1'b1;
  endtask

  task automatic test_random_scans(int target);
    int sent;
    int len;
    sent = 0;
    while (sent < target) begin
      idle_on = ($urandom_range(0, 3) != 0);
      len = scan_len();
      stream_scan(len);
      sent += len;
    end
    drain_results();
    idle_on = 1'b1;
  endtask

  // Step through register extremes and random settings
  task automatic test_register_sweep();
    apply_setting(16'd0, 16'd0, 16'h8000, 16'd0);
    // zero distance passes the near limit but is no hit
    send_point(pt(1, 0, 5, 5, 0), pick_gap());
    send_point(pt(1, 0, 0, 200, 0), pick_gap());
    send_point(pt(1, 7, 5, 5, 1), pick_gap());
    test_random_scans(100);
    // bits above the 15-bit registers are dropped
    apply_setting(16'hFFFF, 16'hFFFF, 16'h7FFF, 16'hFFFF);
    test_random_scans(100);
    // writes to spare indexes change nothing
    repeat (4) write_reg(CfgIdxW'($urandom_range(int'(SpareReg), (1 << CfgIdxW) - 1)),
                         CfgDataW'($urandom));
    test_random_scans(60);
    repeat (3) begin
      apply_setting(16'($urandom_range(0, 2000)),
                    16'($urandom_range(0, 3000)) | 16'($urandom_range(0, 1) << 15),
                    16'(int'($urandom_range(0, 4000)) - 2000),
                    16'($urandom_range(0, 3000)) | 16'($urandom_range(0, 1) << 15));
      test_random_scans(80);
    end
    apply_setting(IgnoreNearRst, 16'(FrontHalfWidthRst), SideMinForwardRst,
                  16'(SideMinLateralRst));
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_scan_overflow();
    test_backpressure();
    test_register_sweep();
    test_random_scans(300);
    if (fail_count == 0 && pending_summaries.size() == 0) begin
      $display("lidar_sector_min_distance_unit_test passed");
    end else begin
      $display("lidar_sector_min_distance_unit_test failed");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #20000000;
    $display("%0t: timeout with %0d summaries pending", $time, pending_summaries.size());
    $display("lidar_sector_min_distance_unit_test failed");
    $finish;
  end

endmodule
